FILE: hw/rtl/unix_time_to_iso_date_text_macros.svh
// assertion macros for the date text block
`ifndef UNIX_TIME_TO_ISO_DATE_TEXT_MACROS_SVH
`define UNIX_TIME_TO_ISO_DATE_TEXT_MACROS_SVH
`ifndef SYNTH
`define ITD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itd check failed");
`define ITD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itd check failed");
`else
`define ITD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ITD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/itd_pkg.sv
package itd_pkg;

	localparam int TextMax = 19;
	localparam int EraMax = 5;
	localparam int CentMax = 4;

	localparam logic [4:0] LenDate = 5'd10;
	localparam logic [4:0] LenFull = 5'd19;

	// 86400 seconds per day split into 2^7 * 675
	localparam logic [9:0] DayUnit = 10'd675;
	localparam logic [15:0] DayRecip = 16'((2 ** 25) / 675);
	localparam logic [19:0] EpochShift = 20'd719468;
	localparam logic [17:0] DaysPerEra = 18'd146097;
	localparam logic [17:0] EraLastDay = 18'd146096;
	localparam logic [17:0] DaysPerCentury = 18'd36524;
	localparam logic [10:0] DaysPer4Yr = 11'd1460;
	localparam logic [8:0] DaysPerYear = 9'd365;
	localparam logic [7:0] MonthSpan = 8'd153;
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [5:0] SecsPerMin = 6'd60;
	localparam logic [6:0] YearsPerCentury = 7'd100;
	localparam logic [8:0] YearsPerEra = 9'd400;

	localparam logic [7:0] Recip4Yr = 8'((2 ** 18) / 1460);
	localparam logic [9:0] RecipYear = 10'((2 ** 18) / 365);
	localparam logic [3:0] RecipSpan = 4'((2 ** 11) / 153);
	localparam logic [5:0] RecipHour = 6'((2 ** 17) / 3600);
	localparam logic [6:0] RecipMin = 7'((2 ** 12) / 60);
	localparam logic [5:0] RecipCent = 6'((2 ** 12) / 100);

	localparam logic [6:0] CharZero = 7'h30;
	localparam logic [6:0] CharDash = 7'h2d;
	localparam logic [6:0] CharSpace = 7'h20;
	localparam logic [6:0] CharColon = 7'h3a;

	typedef logic [6:0] char_t;

	typedef struct packed {
		logic [19:0] z;
		logic [16:0] tod;
		logic [7:0] cap;
	} split_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] cap;
	} date_t;

	typedef struct packed {
		char_t [TextMax-1:0] chars;
		logic [4:0] len;
		logic wr;
	} text_t;

	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic char_t tens_char(input logic [6:0] v);
		return CharZero + 7'(tens_of(v));
	endfunction

	function automatic char_t ones_char(input logic [6:0] v);
		logic [6:0] o;
		o = v - 7'(tens_of(v)) * 7'd10;
		return CharZero + o;
	endfunction

	// first day of year (march based) for each month
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/itd_split.sv
module itd_split (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [31:0] ts,
	input logic [7:0] cap,
	output logic in_ready,
	output logic out_valid,
	output itd_pkg::split_t out_data,
	input logic out_ready
);

	logic vld_s1, vld_s2, rdy_s1, rdy_s2;
	logic [31:0] ts_s1;
	logic [7:0] cap_s1;
	logic [15:0] qe_s1;
	itd_pkg::split_t data_s2;

	logic [40:0] prod;
	logic [25:0] back;
	logic [10:0] rem, remc;
	logic [15:0] days;
	itd_pkg::split_t data_c;

	assign rdy_s2 = !vld_s2 || out_ready;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = vld_s2;
	assign out_data = data_s2;

	assign prod = 41'(ts[31:7]) * 41'(itd_pkg::DayRecip);

	always_comb begin
		back = 26'(qe_s1) * 26'(itd_pkg::DayUnit);
		rem = 11'(26'(ts_s1[31:7]) - back);
		if (rem >= 11'(itd_pkg::DayUnit)) begin
			days = qe_s1 + 16'd1;
			remc = rem - 11'(itd_pkg::DayUnit);
		end else begin
			days = qe_s1;
			remc = rem;
		end
		data_c.z = 20'(days) + itd_pkg::EpochShift;
		data_c.tod = {remc[9:0], ts_s1[6:0]};
		data_c.cap = cap_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ts_s1 <= ts;
			cap_s1 <= cap;
			qe_s1 <= prod[40:25];
		end
		if (rdy_s2) data_s2 <= data_c;
	end

endmodule

FILE: hw/rtl/itd_civil.sv
module itd_civil (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input itd_pkg::split_t in_data,
	output logic in_ready,
	output logic out_valid,
	output itd_pkg::date_t out_data,
	input logic out_ready
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic [2:0] era_s1, era_s2, era_s3, era_s4, era_s5, era_s6, era_s7;
	logic [17:0] doe_s1, doe_s2, doe_s3, doe_s4, doe_s5;
	logic [16:0] tod_s1;
	logic [4:0] he_s1;
	logic [6:0] ae_s2;
	logic [2:0] b_s2;
	logic c_s2;
	logic [4:0] h_s2, h_s3, h_s4, h_s5, h_s6, h_s7;
	logic [11:0] rh_s2, rh_s3;
	logic [17:0] t_s3, t_s4;
	logic [5:0] me_s3;
	logic [8:0] ye_s4, yoe_s5, yoe_s6, yoe_s7;
	logic [5:0] m_s4, m_s5, m_s6, m_s7;
	logic [5:0] s_s4, s_s5, s_s6, s_s7;
	logic [8:0] doy_s6, doy_s7;
	logic [10:0] span_s7;
	logic [3:0] mpe_s7;
	logic [7:0] cap_s1, cap_s2, cap_s3, cap_s4, cap_s5, cap_s6, cap_s7;
	itd_pkg::date_t data_s8;

	logic [2:0] era_c;
	logic [17:0] doe_c;
	logic [22:0] prod_h;
	logic [25:0] prod_a;
	logic [2:0] b_c;
	logic [12:0] rh_w;
	logic [4:0] h_c;
	logic [11:0] rh_c;
	logic [11:0] ra;
	logic [6:0] a_c;
	logic [17:0] t_c;
	logic [18:0] prod_m;
	logic [27:0] prod_y;
	logic [6:0] rm;
	logic [5:0] m_c, s_c;
	logic [9:0] ry;
	logic [8:0] yoe_c;
	logic [1:0] cent;
	logic [17:0] base;
	logic [8:0] doy_c;
	logic [10:0] span_c;
	logic [14:0] prod_s;
	logic [10:0] rs;
	logic [3:0] mp;
	itd_pkg::date_t data_c;

	assign rdy_s8 = !vld_s8 || out_ready;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = vld_s8;
	assign out_data = data_s8;

	// era and hour estimate
	always_comb begin
		era_c = '0;
		for (int k = 1; k <= itd_pkg::EraMax; k++) begin
			if (in_data.z >= 20'(k) * 20'(itd_pkg::DaysPerEra)) era_c = 3'(k);
		end
		doe_c = 18'(in_data.z - 20'(era_c) * 20'(itd_pkg::DaysPerEra));
		prod_h = 23'(in_data.tod) * 23'(itd_pkg::RecipHour);
	end

	// four-year estimate, centuries, hour correction
	always_comb begin
		prod_a = 26'(doe_s1) * 26'(itd_pkg::Recip4Yr);
		b_c = '0;
		for (int k = 1; k <= itd_pkg::CentMax; k++) begin
			if (doe_s1 >= 18'(k) * itd_pkg::DaysPerCentury) b_c = 3'(k);
		end
		rh_w = 13'(tod_s1 - 17'(he_s1) * 17'(itd_pkg::SecsPerHour));
		if (rh_w >= 13'(itd_pkg::SecsPerHour)) begin
			h_c = he_s1 + 5'd1;
			rh_c = 12'(rh_w - 13'(itd_pkg::SecsPerHour));
		end else begin
			h_c = he_s1;
			rh_c = 12'(rh_w);
		end
	end

	// four-year correction, year-of-era numerator, minute estimate
	always_comb begin
		ra = 12'(doe_s2 - 18'(ae_s2) * 18'(itd_pkg::DaysPer4Yr));
		a_c = (ra >= 12'(itd_pkg::DaysPer4Yr)) ? ae_s2 + 7'd1 : ae_s2;
		t_c = doe_s2 - 18'(a_c) + 18'(b_s2) - 18'(c_s2);
		prod_m = 19'(rh_s2) * 19'(itd_pkg::RecipMin);
	end

	// year estimate, minute correction
	always_comb begin
		prod_y = 28'(t_s3) * 28'(itd_pkg::RecipYear);
		rm = 7'(rh_s3 - 12'(me_s3) * 12'(itd_pkg::SecsPerMin));
		if (rm >= 7'(itd_pkg::SecsPerMin)) begin
			m_c = me_s3 + 6'd1;
			s_c = 6'(rm - 7'(itd_pkg::SecsPerMin));
		end else begin
			m_c = me_s3;
			s_c = 6'(rm);
		end
	end

	// year correction
	always_comb begin
		ry = 10'(t_s4 - 18'(ye_s4) * 18'(itd_pkg::DaysPerYear));
		yoe_c = (ry >= 10'(itd_pkg::DaysPerYear)) ? ye_s4 + 9'd1 : ye_s4;
	end

	// day of year
	always_comb begin
		cent = '0;
		for (int k = 1; k < itd_pkg::CentMax; k++) begin
			if (yoe_s5 >= 9'(k) * 9'(itd_pkg::YearsPerCentury)) cent = 2'(k);
		end
		base = 18'(yoe_s5) * 18'(itd_pkg::DaysPerYear) + 18'(yoe_s5[8:2]) - 18'(cent);
		doy_c = 9'(doe_s5 - base);
	end

	// month estimate
	always_comb begin
		span_c = 11'(doy_s6) * 11'd5 + 11'd2;
		prod_s = 15'(span_c) * 15'(itd_pkg::RecipSpan);
	end

	// month correction, day, month and year
	always_comb begin
		rs = span_s7 - 11'(mpe_s7) * 11'(itd_pkg::MonthSpan);
		mp = (rs >= 11'(itd_pkg::MonthSpan)) ? mpe_s7 + 4'd1 : mpe_s7;
		data_c.day = 5'(doy_s7 - itd_pkg::month_start(mp) + 9'd1);
		data_c.month = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		data_c.year = 12'(yoe_s7) + 12'(era_s7) * 12'(itd_pkg::YearsPerEra)
			+ 12'(data_c.month <= 4'd2);
		data_c.hour = h_s7;
		data_c.minute = m_s7;
		data_c.second = s_s7;
		data_c.cap = cap_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			era_s1 <= era_c;
			doe_s1 <= doe_c;
			tod_s1 <= in_data.tod;
			he_s1 <= 5'(prod_h >> 17);
			cap_s1 <= in_data.cap;
		end
		if (rdy_s2) begin
			era_s2 <= era_s1;
			doe_s2 <= doe_s1;
			ae_s2 <= 7'(prod_a >> 18);
			b_s2 <= b_c;
			c_s2 <= (doe_s1 == itd_pkg::EraLastDay);
			h_s2 <= h_c;
			rh_s2 <= rh_c;
			cap_s2 <= cap_s1;
		end
		if (rdy_s3) begin
			era_s3 <= era_s2;
			doe_s3 <= doe_s2;
			t_s3 <= t_c;
			h_s3 <= h_s2;
			rh_s3 <= rh_s2;
			me_s3 <= 6'(prod_m >> 12);
			cap_s3 <= cap_s2;
		end
		if (rdy_s4) begin
			era_s4 <= era_s3;
			doe_s4 <= doe_s3;
			t_s4 <= t_s3;
			ye_s4 <= 9'(prod_y >> 18);
			h_s4 <= h_s3;
			m_s4 <= m_c;
			s_s4 <= s_c;
			cap_s4 <= cap_s3;
		end
		if (rdy_s5) begin
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			yoe_s5 <= yoe_c;
			h_s5 <= h_s4;
			m_s5 <= m_s4;
			s_s5 <= s_s4;
			cap_s5 <= cap_s4;
		end
		if (rdy_s6) begin
			era_s6 <= era_s5;
			yoe_s6 <= yoe_s5;
			doy_s6 <= doy_c;
			h_s6 <= h_s5;
			m_s6 <= m_s5;
			s_s6 <= s_s5;
			cap_s6 <= cap_s5;
		end
		if (rdy_s7) begin
			era_s7 <= era_s6;
			yoe_s7 <= yoe_s6;
			doy_s7 <= doy_s6;
			span_s7 <= span_c;
			mpe_s7 <= 4'(prod_s >> 11);
			h_s7 <= h_s6;
			m_s7 <= m_s6;
			s_s7 <= s_s6;
			cap_s7 <= cap_s6;
		end
		if (rdy_s8) data_s8 <= data_c;
	end

endmodule

FILE: hw/rtl/itd_text.sv
module itd_text (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input itd_pkg::date_t in_data,
	output logic in_ready,
	output logic out_valid,
	output itd_pkg::text_t out_data,
	input logic out_ready
);

	logic vld_s1, vld_s2, rdy_s1, rdy_s2;
	itd_pkg::date_t date_s1;
	logic [4:0] yhe_s1;
	logic [4:0] len_s1;
	logic wr_s1;
	itd_pkg::text_t data_s2;

	logic [17:0] prod;
	logic midnight;
	logic [4:0] len_c;
	logic [11:0] ry;
	logic [6:0] yh, yl;
	itd_pkg::text_t data_c;

	assign rdy_s2 = !vld_s2 || out_ready;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = vld_s2;
	assign out_data = data_s2;

	always_comb begin
		prod = 18'(in_data.year) * 18'(itd_pkg::RecipCent);
		midnight = (in_data.hour == '0) && (in_data.minute == '0) && (in_data.second == '0);
		len_c = midnight ? itd_pkg::LenDate : itd_pkg::LenFull;
	end

	always_comb begin
		ry = date_s1.year - 12'(yhe_s1) * 12'(itd_pkg::YearsPerCentury);
		if (ry >= 12'(itd_pkg::YearsPerCentury)) begin
			yh = 7'(yhe_s1) + 7'd1;
			yl = 7'(ry - 12'(itd_pkg::YearsPerCentury));
		end else begin
			yh = 7'(yhe_s1);
			yl = 7'(ry);
		end
		data_c.chars[0] = itd_pkg::tens_char(yh);
		data_c.chars[1] = itd_pkg::ones_char(yh);
		data_c.chars[2] = itd_pkg::tens_char(yl);
		data_c.chars[3] = itd_pkg::ones_char(yl);
		data_c.chars[4] = itd_pkg::CharDash;
		data_c.chars[5] = itd_pkg::tens_char(7'(date_s1.month));
		data_c.chars[6] = itd_pkg::ones_char(7'(date_s1.month));
		data_c.chars[7] = itd_pkg::CharDash;
		data_c.chars[8] = itd_pkg::tens_char(7'(date_s1.day));
		data_c.chars[9] = itd_pkg::ones_char(7'(date_s1.day));
		data_c.chars[10] = itd_pkg::CharSpace;
		data_c.chars[11] = itd_pkg::tens_char(7'(date_s1.hour));
		data_c.chars[12] = itd_pkg::ones_char(7'(date_s1.hour));
		data_c.chars[13] = itd_pkg::CharColon;
		data_c.chars[14] = itd_pkg::tens_char(7'(date_s1.minute));
		data_c.chars[15] = itd_pkg::ones_char(7'(date_s1.minute));
		data_c.chars[16] = itd_pkg::CharColon;
		data_c.chars[17] = itd_pkg::tens_char(7'(date_s1.second));
		data_c.chars[18] = itd_pkg::ones_char(7'(date_s1.second));
		// short buffer: single result with a zero character
		if (!wr_s1) data_c.chars = '0;
		data_c.len = len_s1;
		data_c.wr = wr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			date_s1 <= in_data;
			yhe_s1 <= 5'(prod >> 12);
			len_s1 <= len_c;
			wr_s1 <= (in_data.cap > 8'(len_c));
		end
		if (rdy_s2) data_s2 <= data_c;
	end

endmodule

FILE: hw/rtl/itd_serial.sv
module itd_serial (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input itd_pkg::text_t in_data,
	output logic in_ready,
	output logic out_valid,
	input logic out_stall,
	output logic [6:0] char_code,
	output logic last,
	output logic [4:0] text_length,
	output logic written
);

	itd_pkg::char_t [itd_pkg::TextMax-1:0] shift_q;
	logic [4:0] cnt_q;
	logic [4:0] len_q;
	logic wr_q;
	logic busy_q;

	logic take, done, load;

	assign take = busy_q && !out_stall;
	assign done = take && (cnt_q == 5'd1);
	assign in_ready = !busy_q || done;
	assign load = in_valid && in_ready;

	assign out_valid = busy_q;
	assign char_code = shift_q[0];
	assign last = (cnt_q == 5'd1);
	assign text_length = len_q;
	assign written = wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= in_data.wr ? in_data.len : 5'd1;
		end else if (take) begin
			busy_q <= (cnt_q != 5'd1);
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= in_data.chars;
			len_q <= in_data.len;
			wr_q <= in_data.wr;
		end else if (take) begin
			shift_q <= {7'd0, shift_q[itd_pkg::TextMax-1:1]};
		end
	end

endmodule

FILE: hw/rtl/unix_time_to_iso_date_text.sv
// channel  dir  fields                                          handshake
// request  in   timestamp[31:0] capacity[7:0]                   req_valid / req_stall
// result   out  char_code[6:0] last text_length[4:0] written    res_valid / res_stall
//
// first character leaves once its request passes the split, civil and text stages
// one character per cycle from the output shift register while res_stall is low:
// 19 characters with time of day, 10 at midnight, 1 when the buffer is too small
// the 12 stage pipeline keeps taking requests while the shift register is busy
// res_stall holds the current character and backs up the pipeline stage by stage
// arst_n clears valid bits and the character count only
`include "unix_time_to_iso_date_text_macros.svh"

module unix_time_to_iso_date_text (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [31:0] timestamp,
	input logic [7:0] capacity,
	output logic res_valid,
	input logic res_stall,
	output logic [6:0] char_code,
	output logic last,
	output logic [4:0] text_length,
	output logic written
);

	logic split_ready, split_valid;
	itd_pkg::split_t split_data;
	logic civil_ready, civil_valid;
	itd_pkg::date_t civil_data;
	logic text_ready, text_valid;
	itd_pkg::text_t text_data;
	logic serial_ready;

	assign req_stall = !split_ready;

	itd_split u_split (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_valid),
		.ts(timestamp),
		.cap(capacity),
		.in_ready(split_ready),
		.out_valid(split_valid),
		.out_data(split_data),
		.out_ready(civil_ready)
	);

	itd_civil u_civil (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(split_valid),
		.in_data(split_data),
		.in_ready(civil_ready),
		.out_valid(civil_valid),
		.out_data(civil_data),
		.out_ready(text_ready)
	);

	itd_text u_text (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(civil_valid),
		.in_data(civil_data),
		.in_ready(text_ready),
		.out_valid(text_valid),
		.out_data(text_data),
		.out_ready(serial_ready)
	);

	itd_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(text_valid),
		.in_data(text_data),
		.in_ready(serial_ready),
		.out_valid(res_valid),
		.out_stall(res_stall),
		.char_code(char_code),
		.last(last),
		.text_length(text_length),
		.written(written)
	);

	`ITD_ASSERT_NOW(a_len_legal, clk, arst_n, res_valid, text_length == itd_pkg::LenDate || text_length == itd_pkg::LenFull)
	`ITD_ASSERT_NOW(a_short_single, clk, arst_n, res_valid && !written, last && char_code == 7'd0)
	`ITD_ASSERT_NOW(a_char_nonzero, clk, arst_n, res_valid && written, char_code != 7'd0)
	`ITD_ASSERT_NEXT(a_text_continues, clk, arst_n, res_valid && !res_stall && !last, res_valid)

endmodule

FILE: sim/unix_time_text_checker.sv
module unix_time_text_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic [31:0] timestamp,
	input logic [7:0] capacity,
	input logic res_valid,
	input logic res_stall,
	input logic [6:0] char_code,
	input logic last,
	input logic [4:0] text_length,
	input logic written,
	output int mismatches,
	output int outstanding,
	output int requests_seen,
	output int chars_seen,
	output int short_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		itd_pkg::char_t code;
		logic last;
		logic [4:0] len;
		logic wr;
	} text_char_t;

	text_char_t expected_chars[$];

	function automatic itd_pkg::char_t digit_of(input int unsigned v);
		return itd_pkg::CharZero + 7'(v % 10);
	endfunction

	task automatic predict_text(input logic [31:0] ts, input logic [7:0] cap);
		int unsigned days, tod, z, era, doe, yoe, year, doy, mp, day, month;
		itd_pkg::char_t txt [itd_pkg::TextMax];
		logic [4:0] len;
		text_char_t item;
		days = ts / 86400;
		tod = ts % 86400;
		z = days + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		year = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		day = doy - (153 * mp + 2) / 5 + 1;
		month = (mp < 10) ? mp + 3 : mp - 9;
		if (month <= 2) begin
			year = year + 1;
		end
		txt[0] = digit_of(year / 1000);
		txt[1] = digit_of(year / 100);
		txt[2] = digit_of(year / 10);
		txt[3] = digit_of(year);
		txt[4] = itd_pkg::CharDash;
		txt[5] = digit_of(month / 10);
		txt[6] = digit_of(month);
		txt[7] = itd_pkg::CharDash;
		txt[8] = digit_of(day / 10);
		txt[9] = digit_of(day);
		if (tod == 0) begin
			len = itd_pkg::LenDate;
		end else begin
			len = itd_pkg::LenFull;
			txt[10] = itd_pkg::CharSpace;
			txt[11] = digit_of(tod / 36000);
			txt[12] = digit_of(tod / 3600);
			txt[13] = itd_pkg::CharColon;
			txt[14] = digit_of((tod % 3600) / 600);
			txt[15] = digit_of((tod % 3600) / 60);
			txt[16] = itd_pkg::CharColon;
			txt[17] = digit_of((tod % 60) / 10);
			txt[18] = digit_of(tod % 60);
		end
		if (int'(cap) < int'(len) + 1) begin
			item = '{code: 7'd0, last: 1'b1, len: len, wr: 1'b0};
			expected_chars.push_back(item);
		end else begin
			for (int k = 0; k < int'(len); k++) begin
				item = '{code: txt[k], last: (k == int'(len) - 1), len: len, wr: 1'b1};
				expected_chars.push_back(item);
			end
		end
	endtask

	task automatic count_mismatch(input string msg);
		if (mismatches < 10) begin
			$display("%s", msg);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin
		text_char_t want;
		text_char_t got;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_text(timestamp, capacity);
				requests_seen++;
			end
			if (res_valid && !res_stall) begin
				got = '{code: char_code, last: last, len: text_length, wr: written};
				chars_seen++;
				if (!written) begin
					short_seen++;
				end
				if (expected_chars.size() == 0) begin
					count_mismatch($sformatf(
						"unexpected result: code %h last %b len %0d written %b",
						got.code, got.last, got.len, got.wr));
				end else begin
					want = expected_chars.pop_front();
					if (got !== want) begin
						count_mismatch($sformatf(
							{"mismatch: expected code %h last %b len %0d written %b, ",
							"got code %h last %b len %0d written %b"},
							want.code, want.last, want.len, want.wr,
							got.code, got.last, got.len, got.wr));
					end
				end
			end
			outstanding = expected_chars.size();
		end
	end

endmodule

FILE: sim/tb_unix_time_to_iso_date_text.sv
module tb_unix_time_to_iso_date_text;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles = 400;
	localparam int ItemsPerPhase = 63;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [31:0] timestamp = '0;
	logic [7:0] capacity = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [6:0] char_code;
	logic last;
	logic [4:0] text_length;
	logic written;

	int mismatches;
	int outstanding;
	int requests_seen;
	int chars_seen;
	int short_seen;

	int phase = 0;
	int tx_idle_pct = 6;
	int rx_idle_pct = 83;
	logic hold_off = 1'b0;
	int cycle_count = 0;

	unix_time_to_iso_date_text dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.timestamp(timestamp),
		.capacity(capacity),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.char_code(char_code),
		.last(last),
		.text_length(text_length),
		.written(written)
	);

	unix_time_text_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.timestamp(timestamp),
		.capacity(capacity),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.char_code(char_code),
		.last(last),
		.text_length(text_length),
		.written(written),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.requests_seen(requests_seen),
		.chars_seen(chars_seen),
		.short_seen(short_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_stall <= hold_off || ($urandom_range(0, 99) < rx_idle_pct);
	end

	// long output hold at full input rate so the pipeline backs up
	initial begin
		wait (phase == 2);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("unix_time_to_iso_date_text test failed");
		$finish;
	end

	task automatic send_request(input logic [31:0] ts, input logic [7:0] cap);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		timestamp <= ts;
		capacity <= cap;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_timestamp();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				return $urandom();
			end
			4, 5: begin
				return 32'(86400 * $urandom_range(0, 49710));
			end
			6: begin
				return 32'(86400 * $urandom_range(0, 49709)
					+ (($urandom_range(0, 1) == 1) ? 86399 : 1));
			end
			7: begin
				return 32'hffff_ffff - 32'($urandom_range(0, 200000));
			end
			default: begin
				return 32'($urandom_range(0, 32'd4102444800));
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_capacity();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			return 8'($urandom_range(20, 255));
		end else if (kind == 7) begin
			return ($urandom_range(0, 1) == 1) ? 8'd11 : 8'd20;
		end else begin
			return 8'($urandom_range(0, 255));
		end
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests
		send_request(32'd0, 8'd11);
		send_request(32'd0, 8'd10);
		send_request(32'd0, 8'd0);
		send_request(32'hffff_ffff, 8'd255);
		send_request(32'hffff_ffff, 8'd20);
		send_request(32'hffff_ffff, 8'd19);
		send_request(32'd86399, 8'd20);
		send_request(32'd86400, 8'd11);
		send_request(32'd68169600, 8'd40);
		send_request(32'd951782400, 8'd12);
		send_request(32'd951868800, 8'd12);
		send_request(32'd951868799, 8'd20);
		send_request(32'd946684799, 8'd255);
		send_request(32'd946684800, 8'd255);
		send_request(32'd4102444799, 8'd20);
		send_request(32'd4107542400, 8'd11);
		send_request(32'd4107542399, 8'd20);
		send_request(32'haaaa_aaaa, 8'haa);
		send_request(32'h5555_5555, 8'h55);
		send_request(32'd4294944000, 8'd10);
		send_request(32'd4294944000, 8'd11);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 83;
				end
				1: begin
					tx_idle_pct = 83;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase = p;
			for (int i = 0; i < ItemsPerPhase; i++) begin
				send_request(pick_timestamp(), pick_capacity());
			end
		end
		req_valid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("%0d timestamps converted, %0d result characters checked, %0d short-buffer replies",
			requests_seen, chars_seen, short_seen);
		$display("ran slow receiver, slow sender and full rate with a %0d-cycle output hold",
			HoldCycles);
		if (mismatches == 0 && outstanding == 0) begin
			$display("unix_time_to_iso_date_text test passed");
		end else begin
			$display("unix_time_to_iso_date_text test failed");
		end
		$finish;
	end

endmodule

FILE: unix_time_to_iso_date_text.f
+incdir+hw/rtl
hw/rtl/itd_pkg.sv
hw/rtl/itd_split.sv
hw/rtl/itd_civil.sv
hw/rtl/itd_text.sv
hw/rtl/itd_serial.sv
hw/rtl/unix_time_to_iso_date_text.sv
sim/unix_time_text_checker.sv
sim/tb_unix_time_to_iso_date_text.sv
